FILE: design/tspr_pkg.sv
package tspr_pkg;

  localparam int VRAM_DEPTH = 16384;
  localparam int VRAM_AW    = 14;
  localparam int PAL_DEPTH  = 64;
  localparam int PAL_AW     = 6;

  localparam int DEF_OBJ_SLOTS      = 40;
  localparam int DEF_SCREEN_COLUMNS = 160;
  localparam int DEF_SCREEN_LINES   = 144;

  localparam logic [7:0] LCDC_RESET = 8'h91;

  typedef enum logic [2:0] {
    FN_VRAM = 3'd0,
    FN_BGPAL = 3'd1,
    FN_OBJPAL = 3'd2,
    FN_OAM = 3'd3,
    FN_RENDER = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    CFG_LCDC = 3'd0,
    CFG_SCY = 3'd1,
    CFG_SCX = 3'd2,
    CFG_WY = 3'd3,
    CFG_WX = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_BG   = 2'd1;
  localparam logic [1:0] SRC_OBJ  = 2'd2;

  // queued item between front and back
  typedef struct packed {
    logic [2:0]  func;
    logic [13:0] address;
    logic [7:0]  data;
    logic [7:0]  line;
    logic [7:0]  column;
    logic        onscreen;
  } item_t;

endpackage

FILE: design/tspr_front.sv
module tspr_front
  import tspr_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_LINES   = DEF_SCREEN_LINES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [13:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_line,
  input  logic [7:0]  in_column,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int QD = 2;

  item_t      mem_r [QD];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      it;
  logic       push;

  assign busy    = (cnt_r == 2'(QD));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    it.func     = in_func;
    it.address  = in_address;
    it.data     = in_data;
    it.line     = in_line;
    it.column   = in_column;
    it.onscreen = (9'(in_line) < 9'(SCREEN_LINES)) && (9'(in_column) < 9'(SCREEN_COLUMNS));
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= it;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: design/tspr_back.sv
module tspr_back
  import tspr_pkg::*;
#(
  parameter int OBJ_SLOTS      = DEF_OBJ_SLOTS,
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_LINES   = DEF_SCREEN_LINES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic [7:0]  lcdc,
  input  logic [7:0]  scy,
  input  logic [7:0]  scx,
  input  logic [7:0]  wy,
  input  logic [7:0]  wx,
  output logic        out_strobe,
  output logic [15:0] out_color,
  output logic [1:0]  out_source
);

  localparam int OAM_DEPTH = 4 * OBJ_SLOTS;
  localparam int OAM_AW    = $clog2(OAM_DEPTH);
  localparam int SW        = $clog2(OBJ_SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MAP_T, S_MAP_A, S_MAP_W, S_TDLO, S_TDHI, S_TDW,
    S_BPLO, S_BPHI, S_BPW,
    S_SY, S_SX, S_ST, S_SA, S_SW, S_SCHK, S_SDLO, S_SDHI, S_SDW,
    S_OPLO, S_OPHI, S_OPW, S_DONE
  } st_t;

  logic [7:0] vram [VRAM_DEPTH];
  logic [7:0] bgp  [PAL_DEPTH];
  logic [7:0] obp  [PAL_DEPTH];
  logic [7:0] oam  [OAM_DEPTH];

  st_t st_r;
  item_t it_r;
  logic [VRAM_AW-1:0] va_r;
  logic [7:0] vq_r, bq_r, oq_r, sq_r;
  logic [PAL_AW-1:0] ba_r, oa_r;
  logic [OAM_AW-1:0] sa_r;
  logic [7:0] bx_r, by_r, tile_r, battr_r, lo_r;
  logic [1:0] bidx_r;
  logic [7:0] bcol_lo_r;
  logic [15:0] color_r;
  logic [1:0] source_r;
  logic [SW-1:0] sn_r;
  logic [7:0] ry_r, rx_r, stile_r, sattr_r;
  logic [2:0] px_r;
  logic strobe_r;

  // memory reads, registered
  always_ff @(posedge clk) begin
    vq_r <= vram[va_r];
    bq_r <= bgp[ba_r];
    oq_r <= obp[oa_r];
    sq_r <= oam[sa_r];
  end

  logic pop_w;
  assign pop_w = (st_r == S_IDLE) && q_valid;
  assign q_pop = pop_w;

  always_ff @(posedge clk) begin
    if (pop_w) begin
      case (q_item.func)
        FN_VRAM: vram[q_item.address] <= q_item.data;
        FN_BGPAL: if (q_item.address < 14'(PAL_DEPTH))
          bgp[q_item.address[PAL_AW-1:0]] <= q_item.data;
        FN_OBJPAL: if (q_item.address < 14'(PAL_DEPTH))
          obp[q_item.address[PAL_AW-1:0]] <= q_item.data;
        FN_OAM: if (q_item.address < 14'(OAM_DEPTH))
          oam[q_item.address[OAM_AW-1:0]] <= q_item.data;
        default: ;
      endcase
    end
  end

  // background coordinate
  logic use_win;
  logic [8:0] c7;
  logic [7:0] bx, by;
  logic [VRAM_AW-1:0] map_a;
  always_comb begin
    c7 = 9'(it_r.column) + 9'd7;
    use_win = lcdc[5] && (wy <= it_r.line) && (c7 >= 9'(wx));
    if (use_win) begin
      bx = 8'(c7 - 9'(wx));
      by = it_r.line - wy;
      map_a = lcdc[6] ? 14'h1C00 : 14'h1800;
    end else begin
      bx = it_r.column + scx;
      by = it_r.line + scy;
      map_a = lcdc[3] ? 14'h1C00 : 14'h1800;
    end
    map_a = map_a + {4'd0, by[7:3], bx[7:3]};
  end

  logic [VRAM_AW-1:0] td_a;
  logic [2:0] tx, ty;
  always_comb begin
    tx = battr_r[5] ? ~bx_r[2:0] : bx_r[2:0];
    ty = battr_r[6] ? ~by_r[2:0] : by_r[2:0];
    if (lcdc[4]) td_a = {2'b00, tile_r, 4'd0};
    else td_a = 14'h0800 + {2'b00, tile_r ^ 8'h80, 4'd0};
    td_a = td_a + (battr_r[3] ? 14'h2000 : 14'h0) + {10'd0, ty, 1'b0};
  end

  // sprite geometry
  logic [3:0] hgt;
  logic hit;
  logic [3:0] srow;
  logic [2:0] spx;
  logic [VRAM_AW-1:0] sd_a;
  logic [7:0] st_t8;
  always_comb begin
    hgt = lcdc[2] ? 4'd15 : 4'd7;
    hit = 1'b0;
    srow = 4'd0;
    spx = 3'd0;
    begin : geo
      logic [9:0] yy, xx, dl, dc;
      yy = 10'(ry_r);
      xx = 10'(rx_r);
      dl = 10'(it_r.line) + 10'd16 - yy;
      dc = 10'(it_r.column) + 10'd8 - xx;
      hit = (ry_r != 8'd0) && (rx_r != 8'd0) &&
            (yy < 10'(SCREEN_LINES) + 10'd16) && (xx < 10'(SCREEN_COLUMNS) + 10'd8) &&
            (10'(it_r.line) + 10'd16 >= yy) && (dl <= 10'(hgt)) &&
            (10'(it_r.column) + 10'd8 >= xx) && (dc <= 10'd7);
      srow = sattr_r[6] ? (hgt - dl[3:0]) : dl[3:0];
      spx  = sattr_r[5] ? ~dc[2:0] : dc[2:0];
    end
    st_t8 = lcdc[2] ? {stile_r[7:1], 1'b0} : stile_r;
    sd_a = {2'b00, st_t8, 4'd0} + {9'd0, srow, 1'b0} + (sattr_r[3] ? 14'h2000 : 14'h0);
  end

  logic [1:0] pix_idx_bg, pix_idx_ob;
  assign pix_idx_bg = {vq_r[3'd7 - tx], lo_r[3'd7 - tx]};
  assign pix_idx_ob = {vq_r[3'd7 - px_r], lo_r[3'd7 - px_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (st_r)
        S_IDLE: if (pop_w && q_item.func == FN_RENDER) begin
          it_r <= q_item;
          color_r <= 16'd0;
          source_r <= SRC_NONE;
          bidx_r <= 2'd0;
          if (!q_item.onscreen) st_r <= S_DONE;
          else if (lcdc[0]) st_r <= S_MAP_T;
          else if (lcdc[1]) st_r <= S_SY;
          else st_r <= S_DONE;
          sn_r <= '0;
        end
        S_MAP_T: begin
          bx_r <= bx; by_r <= by;
          va_r <= map_a;
          st_r <= S_MAP_A;
        end
        S_MAP_A: begin
          va_r <= va_r + 14'h2000;
          st_r <= S_MAP_W;
        end
        S_MAP_W: begin
          tile_r <= vq_r;
          st_r <= S_TDLO;
        end
        S_TDLO: begin
          battr_r <= vq_r;
          st_r <= S_TDHI;
        end
        S_TDHI: begin
          va_r <= td_a;
          st_r <= S_TDW;
        end
        S_TDW: begin
          va_r <= va_r + 14'd1;
          st_r <= S_BPLO;
        end
        S_BPLO: begin
          lo_r <= vq_r;
          st_r <= S_BPHI;
        end
        S_BPHI: begin
          bidx_r <= pix_idx_bg;
          ba_r <= {battr_r[2:0], pix_idx_bg, 1'b0};
          st_r <= S_BPW;
        end
        S_BPW: begin
          // palette address now on the RAM; step to the high byte
          ba_r <= ba_r + 6'd1;
          oa_r <= oa_r + 6'd1;
          st_r <= S_OPLO;
        end
        S_OPLO: begin
          // palette low byte arriving
          if (source_r == SRC_NONE) begin
            bcol_lo_r <= bq_r;
            st_r <= S_OPHI;
          end else begin
            color_r[7:0] <= oq_r;
            st_r <= S_OPHI;
          end
        end
        S_OPHI: begin
          if (source_r == SRC_NONE) begin
            color_r <= {bq_r, bcol_lo_r};
            source_r <= SRC_BG;
            st_r <= lcdc[1] ? S_SY : S_DONE;
          end else begin
            color_r[15:8] <= oq_r;
            st_r <= S_DONE;
          end
        end
        S_SY: begin
          if (sn_r == SW'(OBJ_SLOTS)) st_r <= S_DONE;
          else begin
            sa_r <= OAM_AW'({sn_r, 2'b00});
            st_r <= S_SX;
          end
        end
        S_SX: begin
          sa_r <= sa_r + OAM_AW'(1);
          st_r <= S_ST;
        end
        S_ST: begin
          ry_r <= sq_r;
          sa_r <= sa_r + OAM_AW'(1);
          st_r <= S_SA;
        end
        S_SA: begin
          rx_r <= sq_r;
          sa_r <= sa_r + OAM_AW'(1);
          st_r <= S_SW;
        end
        S_SW: begin
          stile_r <= sq_r;
          st_r <= S_SCHK;
        end
        S_SCHK: begin
          sattr_r <= sq_r;
          st_r <= S_SDLO;
        end
        S_SDLO: begin
          if (!hit) begin
            sn_r <= sn_r + SW'(1);
            st_r <= S_SY;
          end else begin
            px_r <= spx;
            va_r <= sd_a;
            st_r <= S_SDHI;
          end
        end
        S_SDHI: begin
          va_r <= va_r + 14'd1;
          st_r <= S_SDW;
        end
        S_SDW: begin
          lo_r <= vq_r;
          st_r <= S_OPW;
        end
        S_OPW: begin
          if (pix_idx_ob == 2'd0) begin
            sn_r <= sn_r + SW'(1);
            st_r <= S_SY;
          end else if (sattr_r[7] && bidx_r != 2'd0) begin
            st_r <= S_DONE;
          end else begin
            oa_r <= {sattr_r[2:0], pix_idx_ob, 1'b0};
            source_r <= SRC_OBJ;
            st_r <= S_BPW;
          end
        end
        S_DONE: begin
          strobe_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe = strobe_r;
  assign out_color  = color_r;
  assign out_source = source_r;

endmodule

FILE: design/tile_sprite_pixel_renderer_top.sv
// Tile and sprite pixel renderer.
// Input channel: start/busy with in_func, in_address, in_data, in_line,
// in_column; an item is taken when start is high and busy is low.
// Writes (func 0..3) fill video memory, palette RAMs and the sprite table;
// render items (func 4) give one result on out_color/out_source, marked by
// out_strobe for one cycle. The receiver cannot stall.
// A two-entry queue sits between the accepting front end and the render
// sequencer; busy rises only while the queue is full.
// Writes take effect as the back end pops them. An off-screen render goes
// straight to the strobe; a background render reads the map entry, its
// attribute, two tile-data bytes and two palette bytes. Each sprite entry
// scanned reads four table bytes, one that covers the pixel two tile-data
// bytes, and a winning sprite two palette bytes, over one vram/oam read port.
// Items are handled one at a time in order.
// Configuration via cfg_we/cfg_index/cfg_data, written while idle.
// Reset clears control state, loads LCDC_RESET into lcdc and clears the other
// configuration registers; memories are undefined until written.
module tile_sprite_pixel_renderer_top
  import tspr_pkg::*;
#(
  parameter int OBJ_SLOTS      = DEF_OBJ_SLOTS,
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_LINES   = DEF_SCREEN_LINES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [13:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_line,
  input  logic [7:0]  in_column,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_strobe,
  output logic [15:0] out_color,
  output logic [1:0]  out_source
);

  logic [7:0] lcdc_r, scy_r, scx_r, wy_r, wx_r;
  logic q_valid, q_pop;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcdc_r <= LCDC_RESET;
      scy_r <= 8'd0;
      scx_r <= 8'd0;
      wy_r <= 8'd0;
      wx_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LCDC: lcdc_r <= cfg_data;
        CFG_SCY:  scy_r <= cfg_data;
        CFG_SCX:  scx_r <= cfg_data;
        CFG_WY:   wy_r <= cfg_data;
        CFG_WX:   wx_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tspr_front #(.SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_LINES(SCREEN_LINES)) u_front (
    .clk, .rst_n, .start, .busy, .in_func, .in_address, .in_data, .in_line, .in_column,
    .q_valid, .q_item, .q_pop
  );

  tspr_back #(.OBJ_SLOTS(OBJ_SLOTS), .SCREEN_COLUMNS(SCREEN_COLUMNS),
              .SCREEN_LINES(SCREEN_LINES)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .lcdc(lcdc_r), .scy(scy_r), .scx(scx_r), .wy(wy_r), .wx(wx_r),
    .out_strobe, .out_color, .out_source
  );

  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_source != 2'd3))
    else $error("bad source code");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_source == SRC_NONE) |-> (out_color == 16'd0))
    else $error("colour without source");
  a_str: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("double strobe");

endmodule

FILE: sim/tile_sprite_pixel_renderer_top_tb.sv
`timescale 1ns / 1ps

module tile_sprite_pixel_renderer_top_tb;
  import tspr_pkg::*;

  localparam int N_SPRITES  = DEF_OBJ_SLOTS;
  localparam int N_COLS     = DEF_SCREEN_COLUMNS;
  localparam int N_LINES    = DEF_SCREEN_LINES;
  localparam int OAM_BYTES  = 4 * N_SPRITES;
  localparam int DRAIN_WAIT = 300;
  localparam int CYCLE_CAP  = 3000000;
  localparam logic [2:0] FN_SPARE_A = 3'd5;
  localparam logic [2:0] FN_SPARE_B = 3'd6;
  localparam logic [2:0] FN_SPARE_C = 3'd7;

  typedef struct {
    logic [15:0] color;
    logic [1:0]  source;
  } pixel_t;

  class pixel_scoreboard;
    logic [7:0] vram [VRAM_DEPTH];
    logic [7:0] bgpal [PAL_DEPTH];
    logic [7:0] objpal [PAL_DEPTH];
    logic [7:0] oam [OAM_BYTES];
    logic [7:0] lcdc, scy, scx, wy, wx;
    pixel_t     pending_px[$];
    int         errors, checked, renders;

    function new();
      lcdc = LCDC_RESET; scy = 0; scx = 0; wy = 0; wx = 0;
      errors = 0; checked = 0; renders = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [7:0] v);
      case (idx)
        CFG_LCDC: lcdc = v;
        CFG_SCY:  scy = v;
        CFG_SCX:  scx = v;
        CFG_WY:   wy = v;
        CFG_WX:   wx = v;
        default: ;
      endcase
    endfunction

    function logic [15:0] pal_entry(bit obj, logic [2:0] p, logic [1:0] ci);
      logic [5:0] a;
      a = {p, ci, 1'b0};
      if (obj) return {objpal[a + 6'd1], objpal[a]};
      return {bgpal[a + 6'd1], bgpal[a]};
    endfunction

    function logic [1:0] tile_idx(logic [13:0] a, int px);
      logic [7:0] lo, hi;
      lo = vram[a];
      hi = vram[a + 14'd1];
      return {hi[7 - px], lo[7 - px]};
    endfunction

    function logic [15:0] bg_colour(int ln, int col, output logic [1:0] ci);
      logic [7:0] x, y, tile, attr;
      logic [13:0] map, a, d;
      int tx, ty;
      if (lcdc[5] && wy <= ln && col + 7 >= wx) begin
        x = 8'(col + 7 - wx);
        y = 8'(ln - wy);
        map = lcdc[6] ? 14'h1C00 : 14'h1800;
      end else begin
        x = 8'(col + scx);
        y = 8'(ln + scy);
        map = lcdc[3] ? 14'h1C00 : 14'h1800;
      end
      a = map + 14'(y >> 3) * 14'd32 + 14'(x >> 3);
      tile = vram[a];
      attr = vram[a + 14'h2000];
      if (lcdc[4]) d = 14'(tile) * 14'd16;
      else d = 14'h800 + 14'(tile ^ 8'h80) * 14'd16;
      if (attr[3]) d = d + 14'h2000;
      tx = x & 7;
      ty = y & 7;
      if (attr[5]) tx = 7 - tx;
      if (attr[6]) ty = 7 - ty;
      d = d + 14'(ty * 2);
      ci = tile_idx(d, tx);
      return pal_entry(0, attr[2:0], ci);
    endfunction

    function bit sprite_hit(int ln, int col, output logic [15:0] c, output bit behind);
      int h, sy, sx, row, px;
      logic [7:0] tile, attr;
      logic [13:0] a;
      logic [1:0] ci;
      h = lcdc[2] ? 16 : 8;
      for (int s = 0; s < N_SPRITES; s++) begin
        sy = int'(oam[4*s]) - 16;
        sx = int'(oam[4*s+1]) - 8;
        tile = oam[4*s+2];
        attr = oam[4*s+3];
        if (oam[4*s] == 0 || sy >= N_LINES) continue;
        if (oam[4*s+1] == 0 || sx >= N_COLS) continue;
        if (ln < sy || ln >= sy + h || col < sx || col >= sx + 8) continue;
        row = ln - sy;
        px = col - sx;
        if (attr[6]) row = h - 1 - row;
        if (attr[5]) px = 7 - px;
        if (h == 16) tile[0] = 1'b0;
        a = 14'(tile) * 14'd16 + 14'(row * 2) + (attr[3] ? 14'h2000 : 14'h0);
        ci = tile_idx(a, px);
        if (ci == 0) continue;
        c = pal_entry(1, attr[2:0], ci);
        behind = attr[7];
        return 1;
      end
      return 0;
    endfunction

    function void note_item(logic [2:0] fn, logic [13:0] addr, logic [7:0] dat,
                            logic [7:0] ln, logic [7:0] col);
      pixel_t px;
      logic [1:0] ci;
      logic [15:0] sc;
      bit behind;
      case (fn)
        FN_VRAM:   vram[addr] = dat;
        FN_BGPAL:  if (addr < PAL_DEPTH) bgpal[addr] = dat;
        FN_OBJPAL: if (addr < PAL_DEPTH) objpal[addr] = dat;
        FN_OAM:    if (addr < OAM_BYTES) oam[addr] = dat;
        FN_RENDER: begin
          px.color = 0; px.source = SRC_NONE; ci = 0;
          if (ln < N_LINES && col < N_COLS) begin
            if (lcdc[0]) begin
              px.color = bg_colour(ln, col, ci);
              px.source = SRC_BG;
            end
            if (lcdc[1] && sprite_hit(ln, col, sc, behind))
              if (!behind || ci == 0) begin
                px.color = sc;
                px.source = SRC_OBJ;
              end
          end
          pending_px.push_back(px);
          renders++;
        end
        default: ;
      endcase
    endfunction

    function void check(logic [15:0] c, logic [1:0] s);
      pixel_t e;
      checked++;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel: color %h source %0d", c, s);
        return;
      end
      e = pending_px.pop_front();
      if (c !== e.color || s !== e.source) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: expected color %h source %0d, got color %h source %0d",
                   e.color, e.source, c, s);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_func = 0;
  logic [13:0] in_address = 0;
  logic [7:0]  in_data = 0;
  logic [7:0]  in_line = 0;
  logic [7:0]  in_column = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [7:0]  cfg_data = 0;
  logic        out_strobe;
  logic [15:0] out_color;
  logic [1:0]  out_source;

  pixel_scoreboard sb = new();
  int cycles = 0;
  int items_sent = 0;
  int cfg_writes = 0;

  tile_sprite_pixel_renderer_top uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_strobe) sb.check(out_color, out_source);

  // start is left high when the next item follows without a gap
  task automatic send_item(logic [2:0] fn, logic [13:0] addr, logic [7:0] dat,
                           logic [7:0] ln, logic [7:0] col, int gap);
    start = 1; in_func = fn; in_address = addr; in_data = dat;
    in_line = ln; in_column = col;
    do @(posedge clk); while (busy);
    sb.note_item(fn, addr, dat, ln, col);
    items_sent++;
    @(negedge clk);
    if (gap > 0) begin
      start = 0;
      in_func = 3'($urandom); in_address = 14'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic drain();
    start = 0;
    while (sb.pending_px.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] v);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_writes++;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_all(logic [7:0] lc, logic [7:0] sy, logic [7:0] sx,
                         logic [7:0] y, logic [7:0] x);
    drain();
    write_reg(CFG_LCDC, lc);
    write_reg(CFG_SCY, sy);
    write_reg(CFG_SCX, sx);
    write_reg(CFG_WY, y);
    write_reg(CFG_WX, x);
  endtask

  function automatic logic [7:0] oam_byte(int a);
    if (a % 4 == 0) return 8'($urandom_range(0, 175));
    if (a % 4 == 1) return 8'($urandom_range(0, 175));
    return 8'($urandom);
  endfunction

  task automatic random_item(bit quiet);
    int r;
    logic [13:0] a;
    r = $urandom_range(0, 99);
    if (r < 50)
      send_item(FN_RENDER, 14'($urandom), 8'($urandom),
                $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, N_LINES - 1)),
                $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, N_COLS - 1)),
                pick_gap(quiet));
    else if (r < 70)
      send_item(FN_VRAM, 14'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                pick_gap(quiet));
    else if (r < 77) begin
      a = $urandom_range(0, 7) == 0 ? 14'($urandom) : 14'($urandom_range(0, PAL_DEPTH - 1));
      send_item(FN_BGPAL, a, 8'($urandom), 8'($urandom), 8'($urandom), pick_gap(quiet));
    end else if (r < 84) begin
      a = $urandom_range(0, 7) == 0 ? 14'($urandom) : 14'($urandom_range(0, PAL_DEPTH - 1));
      send_item(FN_OBJPAL, a, 8'($urandom), 8'($urandom), 8'($urandom), pick_gap(quiet));
    end else if (r < 96) begin
      a = $urandom_range(0, 7) == 0 ? 14'($urandom) : 14'($urandom_range(0, OAM_BYTES - 1));
      send_item(FN_OAM, a, a < OAM_BYTES ? oam_byte(a) : 8'($urandom),
                8'($urandom), 8'($urandom), pick_gap(quiet));
    end else
      send_item(3'($urandom_range(FN_SPARE_A, FN_SPARE_C)), 14'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), pick_gap(quiet));
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // fill every store so no render reads an unwritten byte
    for (int a = 0; a < VRAM_DEPTH; a++)
      send_item(FN_VRAM, 14'(a), 8'($urandom), 0, 0, 0);
    for (int a = 0; a < PAL_DEPTH; a++) begin
      send_item(FN_BGPAL, 14'(a), 8'($urandom), 0, 0, 0);
      send_item(FN_OBJPAL, 14'(a), 8'($urandom), 0, 0, 0);
    end
    for (int a = 0; a < OAM_BYTES; a++)
      send_item(FN_OAM, 14'(a), oam_byte(a), 0, 0, 0);

    // directed: screen edges, ignored items, sprite over the corner pixel
    send_item(FN_RENDER, 0, 0, 0, 0, 0);
    send_item(FN_RENDER, 0, 0, N_LINES - 1, N_COLS - 1, 1);
    send_item(FN_RENDER, 0, 0, N_LINES, 0, 0);
    send_item(FN_RENDER, 0, 0, 0, N_COLS, 0);
    send_item(FN_RENDER, 14'h3FFF, 8'hFF, 8'hFF, 8'hFF, 0);
    send_item(FN_SPARE_A, 14'h3FFF, 8'hFF, 0, 0, 0);
    send_item(FN_SPARE_B, 0, 0, 0, 0, 0);
    send_item(FN_SPARE_C, 14'h1555, 8'hAA, 0, 0, 0);
    send_item(FN_BGPAL, PAL_DEPTH, 8'h5A, 0, 0, 0);
    send_item(FN_OBJPAL, 14'h3FFF, 8'hA5, 0, 0, 0);
    send_item(FN_OAM, OAM_BYTES, 8'h33, 0, 0, 0);
    send_item(FN_OAM, 0, 8'd16, 0, 0, 0);
    send_item(FN_OAM, 1, 8'd8, 0, 0, 0);
    send_item(FN_OAM, 3, 8'h80, 0, 0, 0);
    send_item(FN_RENDER, 0, 0, 0, 0, 2);
    set_all(8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd7);
    send_item(FN_RENDER, 0, 0, 0, 0, 0);
    send_item(FN_RENDER, 0, 0, 15, 7, 0);
    send_item(FN_RENDER, 0, 0, N_LINES - 1, N_COLS - 1, 0);
    send_item(FN_OAM, 3, 8'h00, 0, 0, 0);
    send_item(FN_RENDER, 0, 0, 0, 0, 0);
    set_all(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
    send_item(FN_RENDER, 0, 0, 5, 5, 0);
    set_all(8'h22, 8'h00, 8'h00, 8'd60, 8'd0);
    send_item(FN_RENDER, 0, 0, 100, 0, 0);
    send_item(FN_RENDER, 0, 0, 10, 80, 0);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_all(LCDC_RESET, 0, 0, 0, 0);
        1: set_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        2: set_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        3: set_all(8'h77, 8'd3, 8'd250, 8'd40, 8'd100);
        default: set_all(8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom_range(0, 160)), 8'($urandom_range(0, 170)));
      endcase
      for (int i = 0; i < 100; i++) random_item(ph == 2 || ph == 6);
    end

    start = 0;
    while (sb.pending_px.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.pending_px.size() > 0) sb.errors++;

    $display("%0d items sent, %0d renders predicted, %0d pixels checked, %0d register writes",
             items_sent, sb.renders, sb.checked, cfg_writes);
    $display("%0d mismatches in %0d cycles", sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
